>>> design/sdf_pkg.sv
`timescale 1ns / 1ps
package sdf_pkg;

  // field and register widths
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned RT_W      = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_HORZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_VERT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_DIAG = 3'd4;

  // reset values of the registers
  localparam logic [CFG_W-1:0] RST_STIFFNESS = 31'd65536;
  localparam logic [CFG_W-1:0] RST_DAMPING   = 31'd0;
  localparam logic [CFG_W-1:0] RST_REST_HORZ = 31'd65536;
  localparam logic [CFG_W-1:0] RST_REST_VERT = 31'd65536;
  localparam logic [CFG_W-1:0] RST_REST_DIAG = 31'd92682;

  // spring kinds
  localparam logic [KIND_W-1:0] KIND_HORZ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERT = 2'd1;

  typedef struct packed {
    logic signed [VAL_W-1:0] delta_x;
    logic signed [VAL_W-1:0] delta_y;
    logic signed [VAL_W-1:0] delta_z;
    logic signed [VAL_W-1:0] rel_vel_x;
    logic signed [VAL_W-1:0] rel_vel_y;
    logic signed [VAL_W-1:0] rel_vel_z;
    logic [KIND_W-1:0]       spring_kind;
  } sdf_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] force_x;
    logic signed [VAL_W-1:0] force_y;
    logic signed [VAL_W-1:0] force_z;
    logic                    degenerate;
  } sdf_out_t;

endpackage

>>> design/sdf_sqrt.sv
`timescale 1ns / 1ps
module sdf_sqrt #(
  parameter int unsigned SW = 1
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [sdf_pkg::SQ_W-1:0] sq_i,
  input  logic [SW-1:0]            side_i,
  output logic [sdf_pkg::RT_W-1:0] root_o,
  output logic [SW-1:0]            side_o
);
  import sdf_pkg::*;

  localparam int unsigned REM_W = RT_W + 3;

  logic [REM_W-1:0] rem_q  [RT_W];
  logic [REM_W-1:0] rem_d  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [RT_W-1:0]  root_d [RT_W];
  logic [SQ_W-1:0]  src_q  [RT_W];
  logic [SQ_W-1:0]  src_d  [RT_W];
  logic [SW-1:0]    side_q [RT_W];

  // one root bit per stage, two radicand bits consumed per stage
  always_comb begin
    logic [REM_W-1:0] prem;
    logic [REM_W-1:0] part;
    logic [REM_W-1:0] trial;
    logic [RT_W-1:0]  proot;
    logic [SQ_W-1:0]  psrc;
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        prem  = '0;
        proot = '0;
        psrc  = sq_i;
      end else begin
        prem  = rem_q[k-1];
        proot = root_q[k-1];
        psrc  = src_q[k-1];
      end
      part  = {prem[RT_W:0], psrc[SQ_W-1 -: 2]};
      trial = {1'b0, proot, 2'b01};
      if (part >= trial) begin
        rem_d[k]  = part - trial;
        root_d[k] = {proot[RT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = part;
        root_d[k] = {proot[RT_W-2:0], 1'b0};
      end
      src_d[k] = psrc << 2;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < RT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        src_q[k]  <= src_d[k];
        if (k > 0) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign root_o = root_q[RT_W-1];
  assign side_o = side_q[RT_W-1];

endmodule

>>> design/sdf_div.sv
`timescale 1ns / 1ps
module sdf_div #(
  parameter int unsigned QW = 31,
  parameter int unsigned VW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [VW-1:0] rem_q  [QW];
  logic [VW-1:0] rem_d  [QW];
  logic [QW-1:0] acc_q  [QW];
  logic [QW-1:0] acc_d  [QW];
  logic [VW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  // restoring division, one quotient bit per stage; acc shifts dividend
  // bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [VW-1:0] prem;
    logic [QW-1:0] pacc;
    logic [VW-1:0] pden;
    logic [VW:0]   part;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        prem = rem_i;
        pacc = num_i;
        pden = den_i;
      end else begin
        prem = rem_q[k-1];
        pacc = acc_q[k-1];
        pden = den_q[k-1];
      end
      part = {prem, pacc[QW-1]};
      if (part >= {1'b0, pden}) begin
        rem_d[k] = VW'(part - {1'b0, pden});
        acc_d[k] = {pacc[QW-2:0], 1'b1};
      end else begin
        rem_d[k] = part[VW-1:0];
        acc_d[k] = {pacc[QW-2:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        acc_q[k] <= acc_d[k];
        if (k > 0) begin
          den_q[k]  <= den_q[k-1];
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign quo_o  = acc_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

>>> design/spring_damper_force.sv
`timescale 1ns / 1ps
// spring_damper_force: force on the first particle of one cloth spring.
// input channel: in_valid_i / in_stall_o carry one spring item (position
// and velocity differences, spring kind); an item is taken at a rising
// edge with in_valid_i high and in_stall_o low.
// output channel: out_valid_o / out_stall_i carry one force item per
// spring, in input order; force and degenerate flag in one struct.
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// write only while no item is in flight.
// throughput: one item per clock, back to back, while in_stall_o is low.
// path: from acceptance to out_valid_o, items pass the 32-stage square
// root, the 63-stage spring-term divider and the 31-stage direction
// dividers in series, plus the multiply and add stages.
// stall: the pipeline advances as one; when the receiver stalls, one more
// item lands in a skid register, then in_stall_o rises until it drains.
// reset: clears all valid bits and loads the register defaults.
module spring_damper_force (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sdf_pkg::sdf_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sdf_pkg::sdf_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdf_pkg::CFG_W-1:0]     cfg_data_i
);
  import sdf_pkg::*;

  localparam int unsigned SF_QW  = 63;   // stiffness * |len - rest| < 2^63
  localparam int unsigned U_QW   = 31;   // |u| <= 2^30
  localparam int unsigned U_FRAC = 30;
  localparam int unsigned VP_W   = 34;
  localparam int unsigned HALF   = 17;
  localparam int unsigned DP_W   = CFG_W + HALF;
  localparam int unsigned M_W    = CFG_W + VP_W;
  localparam int unsigned DFM_W  = M_W - 16;
  localparam int unsigned TM_W   = 33;
  localparam int unsigned FPL_W  = HALF + U_QW;
  localparam int unsigned FPH_W  = TM_W - HALF + U_QW;
  localparam int unsigned PIPE_D = 2 + RT_W + 2 + SF_QW + 1 + U_QW + 11;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] d;
    logic [2:0][VAL_W-1:0] v;
    logic [CFG_W-1:0]      rest;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] d;
    logic [2:0][VAL_W-1:0] v;
    logic [RT_W-1:0]       len;
    logic                  deg;
    logic                  neg;
  } sf_side_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] v;
    logic [63:0]           sf;
    logic                  deg;
    logic [2:0]            usg;
  } u_side_t;

  typedef struct packed {
    logic [2:0][U_QW-1:0] umag;
    logic [2:0]           usg;
    logic                 deg;
  } tail_t;

  // configuration registers
  logic [CFG_W-1:0] stiff_q, damp_q, rest_h_q, rest_v_q, rest_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q  <= RST_STIFFNESS;
      damp_q   <= RST_DAMPING;
      rest_h_q <= RST_REST_HORZ;
      rest_v_q <= RST_REST_VERT;
      rest_g_q <= RST_REST_DIAG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STIFFNESS: stiff_q  <= cfg_data_i;
        CFG_DAMPING:   damp_q   <= cfg_data_i;
        CFG_REST_HORZ: rest_h_q <= cfg_data_i;
        CFG_REST_VERT: rest_v_q <= cfg_data_i;
        CFG_REST_DIAG: rest_g_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline enable and valid bits
  logic              en;
  logic [PIPE_D-1:0] vld_q;
  logic              skid_vld_q, skid_vld_d;
  logic              out_vld_q, out_vld_d;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_D-2:0], in_valid_i};
    end
  end

  // stage: squares of the deltas, rest length select
  logic [2:0][VAL_W-1:0] din, vin, mag0;
  logic [2:0][SQ_W-1:0]  sq0;
  logic [CFG_W-1:0]      rest_sel;

  assign din = {in_data_i.delta_z, in_data_i.delta_y, in_data_i.delta_x};
  assign vin = {in_data_i.rel_vel_z, in_data_i.rel_vel_y, in_data_i.rel_vel_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag0[i] = din[i][VAL_W-1] ? (~din[i] + 1'b1) : din[i];
      sq0[i]  = mag0[i] * mag0[i];
    end
    case (in_data_i.spring_kind)
      KIND_HORZ: rest_sel = rest_h_q;
      KIND_VERT: rest_sel = rest_v_q;
      default:   rest_sel = rest_g_q;
    endcase
    if (rest_sel == '0) begin
      rest_sel = CFG_W'(1);
    end
  end

  logic [2:0][SQ_W-1:0]  s0_sq_q;
  logic [2:0][VAL_W-1:0] s0_d_q, s0_v_q;
  logic [CFG_W-1:0]      s0_rest_q;

  // stage: sum of squares
  logic [SQ_W-1:0] s1_sum_q;
  sq_side_t        s1_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_sq_q   <= sq0;
      s0_d_q    <= din;
      s0_v_q    <= vin;
      s0_rest_q <= rest_sel;
      s1_sum_q  <= s0_sq_q[0] + s0_sq_q[1] + s0_sq_q[2];
      s1_side_q <= '{d: s0_d_q, v: s0_v_q, rest: s0_rest_q};
    end
  end

  // length
  logic [RT_W-1:0] len_w;
  sq_side_t        sqo;

  sdf_sqrt #(
    .SW($bits(sq_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (s1_sum_q),
    .side_i (s1_side_q),
    .root_o (len_w),
    .side_o (sqo)
  );

  // stage: |len - rest| and its sign
  logic [RT_W-1:0] restx, dm2;
  logic            neg2;

  always_comb begin
    restx = {1'b0, sqo.rest};
    if (len_w >= restx) begin
      dm2  = len_w - restx;
      neg2 = 1'b0;
    end else begin
      dm2  = restx - len_w;
      neg2 = 1'b1;
    end
  end

  logic [RT_W-1:0]       s2_len_q, s2_dm_q;
  logic                  s2_neg_q, s2_deg_q;
  logic [CFG_W-1:0]      s2_rest_q;
  logic [2:0][VAL_W-1:0] s2_d_q, s2_v_q;

  // stage: stiffness product
  logic [SF_QW-1:0]      s3_prod_q;
  logic [CFG_W-1:0]      s3_rest_q;
  sf_side_t              s3_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_len_q  <= len_w;
      s2_dm_q   <= dm2;
      s2_neg_q  <= neg2;
      s2_deg_q  <= (len_w == '0);
      s2_rest_q <= sqo.rest;
      s2_d_q    <= sqo.d;
      s2_v_q    <= sqo.v;
      s3_prod_q <= stiff_q * s2_dm_q;
      s3_rest_q <= s2_rest_q;
      s3_side_q <= '{d: s2_d_q, v: s2_v_q, len: s2_len_q, deg: s2_deg_q, neg: s2_neg_q};
    end
  end

  // spring term quotient
  logic [SF_QW-1:0] sf_quo;
  sf_side_t         sfo;

  sdf_div #(
    .QW(SF_QW),
    .VW(CFG_W),
    .SW($bits(sf_side_t))
  ) u_sf_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  ('0),
    .num_i  (s3_prod_q),
    .den_i  (s3_rest_q),
    .side_i (s3_side_q),
    .quo_o  (sf_quo),
    .side_o (sfo)
  );

  // stage: signed spring term, direction divider setup
  logic [63:0]           sf4;
  logic [2:0][VAL_W-1:0] rin4;
  logic [2:0][U_QW-1:0]  num4;
  logic [2:0]            usg4;

  always_comb begin
    logic [VAL_W-1:0] a;
    sf4 = 64'(sf_quo);
    if (sfo.neg) begin
      sf4 = -sf4;
    end
    for (int i = 0; i < 3; i++) begin
      a       = sfo.d[i][VAL_W-1] ? (~sfo.d[i] + 1'b1) : sfo.d[i];
      rin4[i] = {1'b0, a[VAL_W-1:1]};
      num4[i] = {a[0], {U_FRAC{1'b0}}};
      usg4[i] = sfo.d[i][VAL_W-1];
    end
  end

  logic [2:0][VAL_W-1:0] s4_rin_q;
  logic [2:0][U_QW-1:0]  s4_num_q;
  logic [RT_W-1:0]       s4_len_q;
  u_side_t               s4_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_rin_q  <= rin4;
      s4_num_q  <= num4;
      s4_len_q  <= sfo.len;
      s4_side_q <= '{v: sfo.v, sf: sf4, deg: sfo.deg, usg: usg4};
    end
  end

  // unit direction dividers, one per axis
  logic [2:0][U_QW-1:0] u_quo;
  u_side_t              uo;

  sdf_div #(
    .QW(U_QW),
    .VW(VAL_W),
    .SW($bits(u_side_t))
  ) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (s4_rin_q[0]),
    .num_i  (s4_num_q[0]),
    .den_i  (s4_len_q),
    .side_i (s4_side_q),
    .quo_o  (u_quo[0]),
    .side_o (uo)
  );

  sdf_div #(
    .QW(U_QW),
    .VW(VAL_W),
    .SW(1)
  ) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (s4_rin_q[1]),
    .num_i  (s4_num_q[1]),
    .den_i  (s4_len_q),
    .side_i (1'b0),
    .quo_o  (u_quo[1]),
    .side_o ()
  );

  sdf_div #(
    .QW(U_QW),
    .VW(VAL_W),
    .SW(1)
  ) u_div_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (s4_rin_q[2]),
    .num_i  (s4_num_q[2]),
    .den_i  (s4_len_q),
    .side_i (1'b0),
    .quo_o  (u_quo[2]),
    .side_o ()
  );

  // stage: u times relative velocity per axis
  logic [2:0][63:0] p5;

  always_comb begin
    logic signed [VAL_W-1:0] us;
    logic signed [VAL_W-1:0] vs;
    logic signed [63:0]      pr;
    for (int i = 0; i < 3; i++) begin
      us = $signed({1'b0, u_quo[i]});
      if (uo.usg[i]) begin
        us = -us;
      end
      vs    = $signed(uo.v[i]);
      pr    = us * vs;
      p5[i] = pr;
    end
  end

  // stage: damping term down to t = sf + df
  logic [2:0][63:0]  s5_p_q;
  tail_t             s5_tl_q, s6_tl_q, s7_tl_q, s8_tl_q, s9_tl_q, s10_tl_q;
  tail_t             s11_tl_q, s12_tl_q, s13_tl_q;
  logic [63:0]       s5_sf_q, s6_sf_q, s7_sf_q, s8_sf_q, s9_sf_q, s10_sf_q;
  logic [63:0]       s6_dot_q;
  logic              s7_vpn_q, s8_vpn_q, s9_vpn_q;
  logic [VP_W-1:0]   s7_vpm_q;
  logic [DP_W-1:0]   s8_dpl_q, s8_dph_q;
  logic [M_W-1:0]    s9_m_q;
  logic [63:0]       s10_df_q, s11_t_q, s12_tabs_q;
  logic              s12_tneg_q, s13_tneg_q;
  logic [TM_W-1:0]   s13_tmag_q;

  logic [63:0]       dabs7, df10, tabs12;
  logic [DFM_W-1:0]  dfm10;
  logic [TM_W-1:0]   tmag13;

  always_comb begin
    dabs7  = s6_dot_q[63] ? (~s6_dot_q + 1'b1) : s6_dot_q;
    dfm10  = s9_m_q[M_W-1:16];
    df10   = 64'(dfm10);
    if (!s9_vpn_q) begin
      df10 = -df10;
    end
    tabs12 = s11_t_q[63] ? (~s11_t_q + 1'b1) : s11_t_q;
    tmag13 = (s12_tabs_q > 64'h1_0000_0000) ? TM_W'(64'h1_0000_0000) : s12_tabs_q[TM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_p_q     <= p5;
      s5_sf_q    <= uo.sf;
      s5_tl_q    <= '{umag: u_quo, usg: uo.usg, deg: uo.deg};
      s6_dot_q   <= s5_p_q[0] + s5_p_q[1] + s5_p_q[2];
      s6_sf_q    <= s5_sf_q;
      s6_tl_q    <= s5_tl_q;
      s7_vpn_q   <= s6_dot_q[63];
      s7_vpm_q   <= dabs7[63:U_FRAC];
      s7_sf_q    <= s6_sf_q;
      s7_tl_q    <= s6_tl_q;
      s8_dpl_q   <= damp_q * s7_vpm_q[HALF-1:0];
      s8_dph_q   <= damp_q * s7_vpm_q[VP_W-1:HALF];
      s8_vpn_q   <= s7_vpn_q;
      s8_sf_q    <= s7_sf_q;
      s8_tl_q    <= s7_tl_q;
      s9_m_q     <= M_W'(s8_dpl_q) + (M_W'(s8_dph_q) << HALF);
      s9_vpn_q   <= s8_vpn_q;
      s9_sf_q    <= s8_sf_q;
      s9_tl_q    <= s8_tl_q;
      s10_df_q   <= df10;
      s10_sf_q   <= s9_sf_q;
      s10_tl_q   <= s9_tl_q;
      s11_t_q    <= s10_sf_q + s10_df_q;
      s11_tl_q   <= s10_tl_q;
      s12_tneg_q <= s11_t_q[63];
      s12_tabs_q <= tabs12;
      s12_tl_q   <= s11_tl_q;
      s13_tmag_q <= tmag13;
      s13_tneg_q <= s12_tneg_q;
      s13_tl_q   <= s12_tl_q;
    end
  end

  // stage: t times u per axis, as two partial products
  logic [2:0][FPL_W-1:0] s14_fpl_q;
  logic [2:0][FPH_W-1:0] s14_fph_q;
  logic [2:0]            s14_sg_q, s15_sg_q;
  logic                  s14_deg_q, s15_deg_q;
  logic [2:0][TM_W-1:0]  s15_fm_q;
  logic [2:0][63:0]      fsum15;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum15[i] = 64'(s14_fpl_q[i]) + (64'(s14_fph_q[i]) << HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s14_fpl_q[i] <= s13_tmag_q[HALF-1:0] * s13_tl_q.umag[i];
        s14_fph_q[i] <= s13_tmag_q[TM_W-1:HALF] * s13_tl_q.umag[i];
        s14_sg_q[i]  <= s13_tneg_q ^ s13_tl_q.usg[i];
        s15_fm_q[i]  <= fsum15[i][U_FRAC+TM_W-1:U_FRAC];
      end
      s14_deg_q <= s13_tl_q.deg;
      s15_sg_q  <= s14_sg_q;
      s15_deg_q <= s14_deg_q;
    end
  end

  // saturate to 32 bits, zero force for a degenerate spring
  logic [2:0][VAL_W-1:0] frc;
  sdf_out_t              res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s15_deg_q) begin
        frc[i] = '0;
      end else if (!s15_sg_q[i]) begin
        frc[i] = (s15_fm_q[i] > TM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                      : s15_fm_q[i][VAL_W-1:0];
      end else begin
        frc[i] = (s15_fm_q[i] >= TM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                       : (~s15_fm_q[i][VAL_W-1:0] + 1'b1);
      end
    end
    res.force_x    = frc[0];
    res.force_y    = frc[1];
    res.force_z    = frc[2];
    res.degenerate = s15_deg_q;
  end

  // output register and skid register
  logic     take, out_load, out_from_skid, skid_load;
  sdf_out_t out_q, skid_q;

  always_comb begin
    take          = out_vld_q && !out_stall_i;
    out_load      = 1'b0;
    out_from_skid = 1'b0;
    skid_load     = 1'b0;
    out_vld_d     = out_vld_q && !take;
    skid_vld_d    = skid_vld_q;
    if (skid_vld_q) begin
      out_vld_d = 1'b1;
      if (take) begin
        out_load      = 1'b1;
        out_from_skid = 1'b1;
        skid_vld_d    = 1'b0;
      end
    end else if (vld_q[PIPE_D-1]) begin
      out_vld_d = 1'b1;
      if (!out_vld_q || take) begin
        out_load = 1'b1;
      end else begin
        skid_load  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_from_skid ? skid_q : res;
    end
    if (skid_load) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
